FILE: rtl/core/analog_ladder_keypad_decoder_macros.svh
// Assertion macros used by the keypad decoder checker.
`ifndef ANALOG_LADDER_KEYPAD_DECODER_MACROS_SVH
`define ANALOG_LADDER_KEYPAD_DECODER_MACROS_SVH

// Check a property on every rising clk_i edge outside reset.
`define ALKD_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ALKD_CHECK_NEXT(label, ante, cons, msg) \
  `ALKD_CHECK(label, (ante) |=> (cons), msg)

`endif

FILE: rtl/core/alkd_pkg.sv
// Shared types, constants and key window tables of the keypad decoder.
package alkd_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int MAX_SAMPLES_DEF = 64;
  localparam int KEY_COUNT_DEF   = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int WIN_ENTRIES     = 16;

  localparam logic [4:0] NO_KEY      = 5'd16;
  localparam logic [4:0] BLOCKED_KEY = 5'd17;

  localparam logic [6:0]  SPR_RESET      = 7'd8;
  localparam logic [7:0]  SPREAD_RESET   = 8'd26;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [31:0] STANDBY_RESET  = 32'd30000;

  localparam logic [15:0] WIN_LOW [WIN_ENTRIES] = '{
    16'd0,   16'd180, 16'd323, 16'd408, 16'd466, 16'd527, 16'd575, 16'd612,
    16'd645, 16'd673, 16'd700, 16'd721, 16'd745, 16'd762, 16'd778, 16'd793
  };
  localparam logic [15:0] WIN_HIGH [WIN_ENTRIES] = '{
    16'd2,   16'd185, 16'd330, 16'd416, 16'd478, 16'd535, 16'd593, 16'd628,
    16'd670, 16'd696, 16'd720, 16'd740, 16'd761, 16'd777, 16'd792, 16'd804
  };

  typedef enum logic [1:0] {
    CFG_SAMPLES_PER_READ,
    CFG_SPREAD_LIMIT,
    CFG_DEBOUNCE,
    CFG_STANDBY
  } cfg_reg_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_CMP,
    B_DIV,
    B_MATCH,
    B_OUT
  } back_state_e;

  typedef struct packed {
    logic [7:0]  spread_limit;
    logic [15:0] debounce_ms;
    logic [31:0] standby_ms;
  } back_cfg_t;

endpackage

FILE: rtl/core/alkd_fifo.sv
// Short queue of burst and block-event records between front and back.
module alkd_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         rd_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o
);

  localparam int DEPTH = alkd_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_q [DEPTH];
  logic [AW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i & ~full_o;
  assign do_rd   = rd_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/core/alkd_front.sv
// Front end: accept samples, track burst sum/min/max and emit burst and block-event records.
module alkd_front #(
  parameter int SAMPLE_BITS = alkd_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_SAMPLES = alkd_pkg::MAX_SAMPLES_DEF,
  parameter int REC_W       = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  output logic                   full_o,
  input  logic                   func_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [31:0]            now_ms_i,
  input  logic [6:0]             samples_per_read_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output logic [REC_W-1:0]       q_data_o
);

  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int SUMW = SAMPLE_BITS + CW;

  typedef struct packed {
    logic                   blk;
    logic [31:0]            now;
    logic [SUMW-1:0]        sum;
    logic [SAMPLE_BITS-1:0] min;
    logic [SAMPLE_BITS-1:0] max;
    logic [CW-1:0]          n;
  } rec_t;

  logic [SUMW-1:0]        sum_q, sum_d, sum_nx;
  logic [SAMPLE_BITS-1:0] min_q, min_d, min_nx;
  logic [SAMPLE_BITS-1:0] max_q, max_d, max_nx;
  logic [CW-1:0]          cnt_q, cnt_d, cnt_nx;
  logic [CW-1:0]          n;
  logic                   accept, burst_end;
  rec_t                   rec;

  assign full_o = q_full_i;
  assign accept = push_i & ~q_full_i;

  // Clamp the burst length into 1..MAX_SAMPLES.
  always_comb begin
    if (samples_per_read_i == '0) begin
      n = CW'(1);
    end else if (32'(samples_per_read_i) > 32'(MAX_SAMPLES)) begin
      n = CW'(MAX_SAMPLES);
    end else begin
      n = CW'(samples_per_read_i);
    end
  end

  assign min_nx    = (sample_i < min_q) ? sample_i : min_q;
  assign max_nx    = (sample_i > max_q) ? sample_i : max_q;
  assign sum_nx    = sum_q + SUMW'(sample_i);
  assign cnt_nx    = cnt_q + 1'b1;
  assign burst_end = (cnt_nx >= n);

  assign q_push_o = accept & (func_i | burst_end);

  always_comb begin
    rec.blk  = func_i;
    rec.now  = now_ms_i;
    rec.sum  = sum_nx;
    rec.min  = min_nx;
    rec.max  = max_nx;
    rec.n    = n;
    q_data_o = rec;
  end

  always_comb begin
    sum_d = sum_q;
    min_d = min_q;
    max_d = max_q;
    cnt_d = cnt_q;
    if (accept && !func_i) begin
      if (burst_end) begin
        sum_d = '0;
        min_d = '1;
        max_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_nx;
        min_d = min_nx;
        max_d = max_nx;
        cnt_d = cnt_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      min_q <= '1;
      max_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      min_q <= min_d;
      max_q <= max_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/core/alkd_div.sv
// Restoring divider, one quotient bit per cycle.
module alkd_div #(
  parameter int W  = 16,
  parameter int DW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [W-1:0]  dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [W-1:0]  quotient_o
);

  localparam int CNTW = (W > 1) ? $clog2(W) : 1;

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [W-1:0]    quo_q;
  logic [DW-1:0]   rem_q, div_q;
  logic [DW:0]     rem_sh, trial;
  logic            take;

  assign rem_sh     = {rem_q, quo_q[W-1]};
  assign trial      = rem_sh - {1'b0, div_q};
  assign take       = ~trial[DW];
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNTW'(W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[W-2:0], take};
      rem_q <= take ? trial[DW-1:0] : rem_sh[DW-1:0];
    end
  end

endmodule

FILE: rtl/core/alkd_back.sv
// Back end: stability check, average, key match, debounce and standby.
module alkd_back #(
  parameter int SAMPLE_BITS = alkd_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_SAMPLES = alkd_pkg::MAX_SAMPLES_DEF,
  parameter int KEY_COUNT   = alkd_pkg::KEY_COUNT_DEF,
  parameter int REC_W       = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  alkd_pkg::back_cfg_t cfg_i,
  input  logic                q_empty_i,
  input  logic [REC_W-1:0]    q_data_i,
  output logic                q_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output logic [4:0]          key_o,
  output logic                standby_o
);

  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int SUMW = SAMPLE_BITS + CW;
  localparam int BW   = SUMW + 8;

  typedef struct packed {
    logic                   blk;
    logic [31:0]            now;
    logic [SUMW-1:0]        sum;
    logic [SAMPLE_BITS-1:0] min;
    logic [SAMPLE_BITS-1:0] max;
    logic [CW-1:0]          n;
  } rec_t;

  alkd_pkg::back_state_e state_q, state_d;

  rec_t                   rec;
  logic [31:0]            now_q;
  logic [SUMW-1:0]        sum_q;
  logic [SAMPLE_BITS-1:0] min_q, max_q;
  logic [CW-1:0]          n_q;
  logic [SUMW-1:0]        spread_q;
  logic [BW-1:0]          bound_q;
  logic                   stable_q;
  logic [4:0]             held_q, key_q;
  logic [31:0]            last_q;
  logic                   standby_q;

  logic                   div_start, div_done;
  logic [SUMW-1:0]        avg;
  logic [4:0]             raw, raw_sel;
  logic                   found, key_edge, change;
  logic [31:0]            elapsed;

  assign rec = q_data_i;

  alkd_div #(
    .W  (SUMW),
    .DW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quotient_o (avg)
  );

  // First window that holds the average wins.
  always_comb begin
    raw   = alkd_pkg::NO_KEY;
    found = 1'b0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (!found && (32'(avg) >= 32'(alkd_pkg::WIN_LOW[i])) &&
          (32'(avg) <= 32'(alkd_pkg::WIN_HIGH[i]))) begin
        raw   = 5'(i);
        found = 1'b1;
      end
    end
  end

  assign raw_sel  = stable_q ? raw : alkd_pkg::NO_KEY;
  assign key_edge = (held_q == alkd_pkg::NO_KEY) ? (raw_sel != alkd_pkg::NO_KEY)
                                                 : (raw_sel == alkd_pkg::NO_KEY);
  assign elapsed  = now_q - last_q;
  assign change   = key_edge && (elapsed > 32'(cfg_i.debounce_ms));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      alkd_pkg::B_IDLE: begin
        if (!q_empty_i && !rec.blk) begin
          state_d = alkd_pkg::B_MUL;
        end
      end
      alkd_pkg::B_MUL:   state_d = alkd_pkg::B_CMP;
      alkd_pkg::B_CMP:   state_d = alkd_pkg::B_DIV;
      alkd_pkg::B_DIV: begin
        if (div_done) begin
          state_d = alkd_pkg::B_MATCH;
        end
      end
      alkd_pkg::B_MATCH: state_d = alkd_pkg::B_OUT;
      alkd_pkg::B_OUT: begin
        if (pop_i) begin
          state_d = alkd_pkg::B_IDLE;
        end
      end
      default:           state_d = alkd_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o   = (state_q == alkd_pkg::B_IDLE) && !q_empty_i;
    div_start = (state_q == alkd_pkg::B_CMP);
    empty_o   = (state_q != alkd_pkg::B_OUT);
  end

  assign key_o     = key_q;
  assign standby_o = standby_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= alkd_pkg::B_IDLE;
      held_q  <= alkd_pkg::NO_KEY;
      last_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == alkd_pkg::B_IDLE && !q_empty_i && rec.blk) begin
        held_q <= alkd_pkg::BLOCKED_KEY;
      end else if (state_q == alkd_pkg::B_MATCH && change) begin
        held_q <= raw_sel;
        last_q <= now_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      alkd_pkg::B_IDLE: begin
        now_q <= rec.now;
        sum_q <= rec.sum;
        min_q <= rec.min;
        max_q <= rec.max;
        n_q   <= rec.n;
      end
      alkd_pkg::B_MUL: begin
        spread_q <= SUMW'(max_q - min_q) * SUMW'(n_q);
        bound_q  <= BW'(cfg_i.spread_limit) * BW'(sum_q);
      end
      alkd_pkg::B_CMP: begin
        stable_q <= (sum_q == '0) || ({spread_q, 8'd0} < bound_q);
      end
      alkd_pkg::B_MATCH: begin
        key_q     <= change ? raw_sel : alkd_pkg::NO_KEY;
        standby_q <= change ? 1'b0 : (elapsed > cfg_i.standby_ms);
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/analog_ladder_keypad_decoder.sv
// Top level of the resistor-ladder keypad decoder.
//
// Input queue side: present func_i/sample_i/now_ms_i with push; a transaction
// completes on a clock edge with push high and full low. func_i = 0 carries
// one ADC sample, func_i = 1 is a block wake-up event that yields no result.
// Result queue side: while empty is low, key_o/standby_o show the oldest
// result; it leaves on an edge with pop high. One result comes per burst.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 samples per read, 1 spread limit, 2 debounce, 3 standby); write only
// while the block is idle.
// Timing: the front end takes one sample per cycle while full is low; a
// burst-end transaction lands in a two-entry record queue. The back end
// takes one record at a time through multiply, compare, divide and match
// states before it shows the result; its bit-serial divider forms the
// average sum / N.
// When pop stays low the finished result holds, the back end stops, the
// record queue fills and full rises; samples inside a burst keep flowing
// until then. Reset clears the burst, sets no key held, restores the
// register defaults and empties both queues.
module analog_ladder_keypad_decoder #(
  parameter int SAMPLE_BITS = alkd_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_SAMPLES = alkd_pkg::MAX_SAMPLES_DEF,
  parameter int KEY_COUNT   = alkd_pkg::KEY_COUNT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input queue
  input  logic                   push,
  output logic                   full,
  input  logic                   func_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [31:0]            now_ms_i,
  // result queue
  output logic                   empty,
  input  logic                   pop,
  output logic [4:0]             key_o,
  output logic                   standby_o,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [31:0]            cfg_wdata_i
);

  localparam int CW    = $clog2(MAX_SAMPLES + 1);
  localparam int SUMW  = SAMPLE_BITS + CW;
  localparam int REC_W = 1 + 32 + SUMW + 2 * SAMPLE_BITS + CW;

  logic [6:0]          spr_q;
  alkd_pkg::back_cfg_t bcfg_q;

  logic                q_push, q_full, q_pop, q_empty;
  logic [REC_W-1:0]    q_wdata, q_rdata;

  // Configuration registers; writes land immediately.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_q               <= alkd_pkg::SPR_RESET;
      bcfg_q.spread_limit <= alkd_pkg::SPREAD_RESET;
      bcfg_q.debounce_ms  <= alkd_pkg::DEBOUNCE_RESET;
      bcfg_q.standby_ms   <= alkd_pkg::STANDBY_RESET;
    end else if (cfg_we_i) begin
      unique case (alkd_pkg::cfg_reg_e'(cfg_idx_i))
        alkd_pkg::CFG_SAMPLES_PER_READ: spr_q               <= cfg_wdata_i[6:0];
        alkd_pkg::CFG_SPREAD_LIMIT:     bcfg_q.spread_limit <= cfg_wdata_i[7:0];
        alkd_pkg::CFG_DEBOUNCE:         bcfg_q.debounce_ms  <= cfg_wdata_i[15:0];
        alkd_pkg::CFG_STANDBY:          bcfg_q.standby_ms   <= cfg_wdata_i;
      endcase
    end
  end

  // Front end: accumulate the burst, forward burst ends and block events.
  alkd_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_SAMPLES (MAX_SAMPLES),
    .REC_W       (REC_W)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push_i             (push),
    .full_o             (full),
    .func_i             (func_i),
    .sample_i           (sample_i),
    .now_ms_i           (now_ms_i),
    .samples_per_read_i (spr_q),
    .q_full_i           (q_full),
    .q_push_o           (q_push),
    .q_data_o           (q_wdata)
  );

  // Record queue decouples sample intake from burst evaluation.
  alkd_fifo #(
    .W (REC_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .rd_i    (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  // Back end: classify, debounce and hold the result until popped.
  alkd_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_SAMPLES (MAX_SAMPLES),
    .KEY_COUNT   (KEY_COUNT),
    .REC_W       (REC_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (bcfg_q),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .key_o     (key_o),
    .standby_o (standby_o)
  );

endmodule

FILE: rtl/core/alkd_checker.sv
// Port-level checker for the keypad decoder, bound to the top level.
`include "analog_ladder_keypad_decoder_macros.svh"

module alkd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [4:0] key_o,
  input logic       standby_o
);

  `ALKD_CHECK(a_key_range, !empty |-> (key_o <= alkd_pkg::NO_KEY), "key out of range")
  `ALKD_CHECK(a_press_clears_standby, (!empty && key_o != alkd_pkg::NO_KEY) |-> !standby_o, "standby on press")
  `ALKD_CHECK_NEXT(a_pop_drains, pop && !empty, empty, "result queue refilled at once")
  `ALKD_CHECK_NEXT(a_result_holds, !empty && !pop, !empty && $stable(key_o) && $stable(standby_o), "stalled result changed")

endmodule

bind analog_ladder_keypad_decoder alkd_checker u_alkd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .empty     (empty),
  .pop       (pop),
  .key_o     (key_o),
  .standby_o (standby_o)
);
